>>> hdl/hkrd_pkg.sv
`default_nettype none

package hkrd_pkg;

  // Sizes
  localparam int REPORT_KEYS  = 6;
  localparam int KEYMAP_DEPTH = 256;
  localparam int NUM_MODS     = 8;
  localparam int SLOT_W       = (REPORT_KEYS > 1) ? $clog2(REPORT_KEYS) : 1;
  localparam int KMAP_AW      = (KEYMAP_DEPTH > 1) ? $clog2(KEYMAP_DEPTH) : 1;
  localparam int KMAP_DW      = 16;
  localparam int NUM_STEPS    = 2 * REPORT_KEYS + 2 * NUM_MODS;
  localparam int STEP_W       = $clog2(NUM_STEPS);

  // Input tdata layout (report always carries six slots)
  localparam int IN_SLOTS      = 6;
  localparam int MODS_LSB      = 0;
  localparam int SLOT_LSB      = 8;
  localparam int MAP_INDEX_LSB = SLOT_LSB + 8 * IN_SLOTS;
  localparam int MAP_LOWER_LSB = MAP_INDEX_LSB + 8;
  localparam int MAP_UPPER_LSB = MAP_LOWER_LSB + 8;
  localparam int LED_LSB       = MAP_UPPER_LSB + 8;
  localparam int IN_FIELD_W    = LED_LSB + 3;
  localparam int IN_DATA_W     = ((IN_FIELD_W + 7) / 8) * 8;

  // Key codes and masks
  localparam logic [7:0] KEY_CAPS         = 8'h39;
  localparam logic [7:0] KEY_SCROLL       = 8'h47;
  localparam logic [7:0] KEY_NUM          = 8'h53;
  localparam logic [7:0] MOD_FIRST        = 8'hE0;
  localparam logic [7:0] RAW_DIRECT_LIMIT = 8'h58;
  localparam logic [7:0] RAW_MOD_BASE     = 8'h58;
  localparam logic [7:0] RAW_HI_TAG       = 8'h70;
  localparam logic [7:0] RAW_LO_TAG       = 8'h60;
  localparam logic [7:0] RAW_RELEASE      = 8'h80;
  localparam logic [7:0] NIBBLE_MASK      = 8'h0F;
  localparam logic [7:0] CASE_OFFSET      = 8'h20;
  localparam logic [7:0] CTRL_CHAR_MASK   = 8'h1F;
  localparam logic [7:0] EXT_FIRST        = 8'h9E;
  localparam logic [7:0] EXT_LAST         = 8'hA9;
  localparam logic [7:0] EXT_OFFSET       = 8'h70;
  localparam logic [7:0] SHIFT_MASK       = 8'h22;
  localparam logic [7:0] CTRL_MASK        = 8'h11;
  localparam logic [7:0] CHAR_LOWER_A     = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z     = 8'h7A;

  localparam int LED_NUM_BIT    = 0;
  localparam int LED_CAPS_BIT   = 1;
  localparam int LED_SCROLL_BIT = 2;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_LED  = 1'b1;

  typedef enum logic [1:0] {
    REQ_REPORT    = 2'd0,
    REQ_MAP_WRITE = 2'd1,
    REQ_LED_SET   = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    CFG_KEYMAP_ENABLE  = 2'd0,
    CFG_KEYMAP_SIZE    = 2'd1,
    CFG_EXTENDED_ASCII = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_EMIT,
    ST_EMIT2,
    ST_LEDS,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic       keymap_enable;
    logic [8:0] keymap_size;
    logic       extended_ascii;
  } cfg_t;

  typedef struct packed {
    logic [7:0]         key;
    logic               press;
    logic [7:0]         mods;
    logic [KMAP_DW-1:0] entry;
    logic [2:0]         leds;
    cfg_t               cfg;
  } enc_in_t;

  typedef struct packed {
    logic       b0_vld;
    logic [7:0] b0;
    logic       b1_vld;
    logic [7:0] b1;
    logic [2:0] leds_nxt;
  } enc_out_t;

  typedef struct packed {
    logic       push;
    logic       flush;
    logic       kind;
    logic [7:0] data;
  } emit_t;

endpackage

`default_nettype wire

>>> hdl/hkrd_ram.sv
`default_nettype none

module hkrd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hdl/hkrd_enc.sv
`default_nettype none

// Event encoder: turns one key event into up to two bytes and the lock LED update.
module hkrd_enc import hkrd_pkg::*; (
  input  wire enc_in_t enc_i,
  output enc_out_t     enc_o
);

  logic [7:0] rel;
  logic [7:0] ch;
  logic       in_range;

  always_comb begin
    enc_o          = '0;
    enc_o.leds_nxt = enc_i.leds;
    rel            = enc_i.press ? 8'h00 : RAW_RELEASE;
    ch             = '0;
    in_range       = 1'b0;

    if (!enc_i.cfg.keymap_enable) begin
      enc_o.b0_vld = 1'b1;
      if (enc_i.key < RAW_DIRECT_LIMIT) begin
        enc_o.b0 = enc_i.key | rel;
      end else if (enc_i.key[7:3] == MOD_FIRST[7:3]) begin
        enc_o.b0 = (RAW_MOD_BASE + {5'b0, enc_i.key[2:0]}) | rel;
      end else begin
        enc_o.b0     = RAW_HI_TAG | {4'b0, enc_i.key[7:4]} | rel;
        enc_o.b1_vld = 1'b1;
        enc_o.b1     = RAW_LO_TAG | (enc_i.key & NIBBLE_MASK) | rel;
      end
    end else if (enc_i.press) begin
      // toggle lock LEDs first; caps and numlock below see the new state
      if (enc_i.key == KEY_CAPS)   enc_o.leds_nxt[LED_CAPS_BIT]   = ~enc_i.leds[LED_CAPS_BIT];
      if (enc_i.key == KEY_SCROLL) enc_o.leds_nxt[LED_SCROLL_BIT] = ~enc_i.leds[LED_SCROLL_BIT];
      if (enc_i.key == KEY_NUM)    enc_o.leds_nxt[LED_NUM_BIT]    = ~enc_i.leds[LED_NUM_BIT];

      in_range = ({1'b0, enc_i.key} < enc_i.cfg.keymap_size) &&
                 ({1'b0, enc_i.key} < 9'(KEYMAP_DEPTH));
      ch = ((enc_i.mods & SHIFT_MASK) != 8'h00) ? enc_i.entry[15:8] : enc_i.entry[7:0];

      if (in_range && (ch != 8'h00)) begin
        if (enc_o.leds_nxt[LED_CAPS_BIT] && (ch inside {[CHAR_LOWER_A:CHAR_LOWER_Z]})) begin
          ch = ch - CASE_OFFSET;
        end
        if (enc_i.cfg.extended_ascii && enc_o.leds_nxt[LED_NUM_BIT] &&
            (ch inside {[EXT_FIRST:EXT_LAST]})) begin
          ch = ch - EXT_OFFSET;
        end
        if ((enc_i.mods & CTRL_MASK) != 8'h00) begin
          ch = ch & CTRL_CHAR_MASK;
        end
        enc_o.b0_vld = 1'b1;
        enc_o.b0     = ch;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/hkrd_seq.sv
`default_nettype none

// Sequencer: feeds events to the encoder, walking the report diff one step a cycle between events.
module hkrd_seq import hkrd_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_valid_i,
  output logic                      s_ready_o,
  input  wire logic [1:0]           req_i,
  input  wire logic [IN_DATA_W-1:0] data_i,
  input  wire cfg_t                 cfg_i,
  input  wire logic                 emit_rdy_i,
  output emit_t                     emit_o,
  output logic                      ram_we_o,
  output logic [KMAP_AW-1:0]        ram_waddr_o,
  output logic [KMAP_DW-1:0]        ram_wdata_o,
  output logic                      ram_re_o,
  output logic [KMAP_AW-1:0]        ram_raddr_o,
  input  wire logic [KMAP_DW-1:0]   ram_rdata_i,
  output enc_in_t                   enc_o,
  input  wire enc_out_t             enc_i
);

  state_e state_q, state_d;

  logic [STEP_W-1:0] step_q;
  logic [7:0]        mods_q, prev_mods_q;
  logic [7:0]        new_q  [REPORT_KEYS];
  logic [7:0]        prev_q [REPORT_KEYS];
  logic [2:0]        leds_q, leds_before_q;
  logic [7:0]        key_q;
  logic              press_q;

  // step decode
  logic              is_new, is_modp, is_modr, last_step;
  logic [STEP_W-1:0] modp_off, modr_off, old_off;
  logic [2:0]        mod_idx;
  logic [SLOT_W-1:0] slot_idx;
  logic [7:0]        cur_key;
  logic              found;
  logic [SLOT_W-1:0] found_idx;
  logic              ev_vld, ev_press, clr_vld;
  logic [7:0]        ev_key;

  // control
  logic accept, step_inc, leds_upd, commit;
  req_e req;
  logic map_in_range;

  assign req          = req_e'(req_i);
  assign accept       = s_valid_i && s_ready_o;
  assign map_in_range = {1'b0, data_i[MAP_INDEX_LSB +: 8]} < 9'(KEYMAP_DEPTH);

  always_comb begin
    is_new    = step_q < STEP_W'(REPORT_KEYS);
    is_modp   = !is_new && (step_q < STEP_W'(REPORT_KEYS + NUM_MODS));
    is_modr   = !is_new && !is_modp && (step_q < STEP_W'(REPORT_KEYS + 2 * NUM_MODS));
    last_step = step_q == STEP_W'(NUM_STEPS - 1);
    modp_off  = step_q - STEP_W'(REPORT_KEYS);
    modr_off  = step_q - STEP_W'(REPORT_KEYS + NUM_MODS);
    old_off   = step_q - STEP_W'(REPORT_KEYS + 2 * NUM_MODS);
    mod_idx   = is_modp ? modp_off[2:0] : modr_off[2:0];
    slot_idx  = is_new ? step_q[SLOT_W-1:0] : old_off[SLOT_W-1:0];
    cur_key   = is_new ? new_q[slot_idx] : prev_q[slot_idx];

    // first old slot holding the same code
    found     = 1'b0;
    found_idx = '0;
    for (int j = REPORT_KEYS - 1; j >= 0; j--) begin
      if (prev_q[j] == cur_key) begin
        found     = 1'b1;
        found_idx = SLOT_W'(j);
      end
    end

    ev_vld   = 1'b0;
    ev_press = 1'b0;
    ev_key   = cur_key;
    clr_vld  = 1'b0;
    if (is_new) begin
      if (cur_key != 8'h00) begin
        clr_vld  = found;
        ev_vld   = !found;
        ev_press = 1'b1;
      end
    end else if (is_modp) begin
      ev_key   = {MOD_FIRST[7:3], mod_idx};
      ev_vld   = mods_q[mod_idx] && !prev_mods_q[mod_idx];
      ev_press = 1'b1;
    end else if (is_modr) begin
      ev_key = {MOD_FIRST[7:3], mod_idx};
      ev_vld = !mods_q[mod_idx] && prev_mods_q[mod_idx];
    end else begin
      ev_vld = cur_key != 8'h00;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          case (req)
            REQ_REPORT:  state_d = ST_STEP;
            REQ_LED_SET: state_d = ST_FLUSH;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_STEP: begin
        if (ev_vld)         state_d = ST_EMIT;
        else if (last_step) state_d = ST_LEDS;
      end
      ST_EMIT: begin
        if (!enc_i.b0_vld || emit_rdy_i) begin
          if (enc_i.b1_vld)   state_d = ST_EMIT2;
          else if (last_step) state_d = ST_LEDS;
          else                state_d = ST_STEP;
        end
      end
      ST_EMIT2: begin
        if (emit_rdy_i) state_d = last_step ? ST_LEDS : ST_STEP;
      end
      ST_LEDS: begin
        if ((leds_q == leds_before_q) || emit_rdy_i) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (emit_rdy_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_ready_o   = 1'b0;
    emit_o      = '0;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    step_inc    = 1'b0;
    leds_upd    = 1'b0;
    commit      = 1'b0;
    ram_waddr_o = data_i[MAP_INDEX_LSB +: KMAP_AW];
    ram_wdata_o = {data_i[MAP_UPPER_LSB +: 8], data_i[MAP_LOWER_LSB +: 8]};
    ram_raddr_o = ev_key[KMAP_AW-1:0];
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        ram_we_o  = s_valid_i && (req == REQ_MAP_WRITE) && map_in_range;
        if (s_valid_i && (req == REQ_LED_SET)) begin
          emit_o.push = 1'b1;
          emit_o.kind = KIND_LED;
          emit_o.data = {5'b0, data_i[LED_LSB +: 3]};
        end
      end
      ST_STEP: begin
        ram_re_o = ev_vld;
        step_inc = !ev_vld && !last_step;
      end
      ST_EMIT: begin
        emit_o.push = enc_i.b0_vld;
        emit_o.kind = KIND_CHAR;
        emit_o.data = enc_i.b0;
        leds_upd    = !enc_i.b0_vld || emit_rdy_i;
        step_inc    = leds_upd && !enc_i.b1_vld && !last_step;
      end
      ST_EMIT2: begin
        emit_o.push = 1'b1;
        emit_o.kind = KIND_CHAR;
        emit_o.data = enc_i.b1;
        step_inc    = emit_rdy_i && !last_step;
      end
      ST_LEDS: begin
        emit_o.push = leds_q != leds_before_q;
        emit_o.kind = KIND_LED;
        emit_o.data = {5'b0, leds_q};
        commit      = (leds_q == leds_before_q) || emit_rdy_i;
      end
      ST_FLUSH: begin
        emit_o.flush = 1'b1;
      end
      default: ;
    endcase
  end

  assign enc_o.key   = key_q;
  assign enc_o.press = press_q;
  assign enc_o.mods  = mods_q;
  assign enc_o.entry = ram_rdata_i;
  assign enc_o.leds  = leds_q;
  assign enc_o.cfg   = cfg_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      prev_mods_q <= '0;
      leds_q      <= '0;
      for (int i = 0; i < REPORT_KEYS; i++) prev_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (accept && (req == REQ_REPORT)) begin
        step_q <= '0;
      end else if (step_inc) begin
        step_q <= step_q + 1'b1;
      end
      if (accept && (req == REQ_LED_SET)) begin
        leds_q <= data_i[LED_LSB +: 3];
      end else if (leds_upd) begin
        leds_q <= enc_i.leds_nxt;
      end
      if ((state_q == ST_STEP) && clr_vld) begin
        prev_q[found_idx] <= '0;
      end
      if (commit) begin
        prev_mods_q <= mods_q;
        for (int i = 0; i < REPORT_KEYS; i++) prev_q[i] <= new_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (req == REQ_REPORT)) begin
      mods_q        <= data_i[MODS_LSB +: 8];
      leds_before_q <= leds_q;
      for (int i = 0; i < REPORT_KEYS; i++) new_q[i] <= data_i[SLOT_LSB + 8 * i +: 8];
    end
    if ((state_q == ST_STEP) && ev_vld) begin
      key_q   <= ev_key;
      press_q <= ev_press;
    end
  end

endmodule

`default_nettype wire

>>> hdl/hid_keyboard_report_decoder.sv
`default_nettype none

// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid_i/tready_o       tuser: req_type; tdata: report/keymap/LED
// m_axis    out  m_axis_tvalid_o/tready_i       tuser: out_kind; tdata: out_byte; tlast
// cfg       in   cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// A report walks every slot and modifier step of the diff, emitting each key event and
// a second raw byte where needed; the event encoder and the single keymap read port
// handle one event at a time. Keymap writes and unused request types complete in idle,
// a host LED set passes through the flush state. Reset clears the previous report, the
// lock LEDs and the config; the keymap is not cleared. A stalled output holds the
// sequencer only once a second result is ready behind the output register.
module hid_keyboard_report_decoder import hkrd_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // s_axis_tdata_i from bit 0: pressed_modifiers, key_slot_0..key_slot_5, map_index,
  // map_lower, map_upper, led_value, zero fill
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [IN_DATA_W-1:0] s_axis_tdata_i,
  input  wire logic [1:0]           s_axis_tuser_i,   // req_type
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic [7:0]                m_axis_tdata_o,   // out_byte
  output logic                      m_axis_tuser_o,   // out_kind
  output logic                      m_axis_tlast_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [8:0]           cfg_data_i
);

  cfg_t cfg_q;

  emit_t    emit;
  logic     emit_rdy;
  enc_in_t  enc_in;
  enc_out_t enc_out;

  logic               ram_we, ram_re;
  logic [KMAP_AW-1:0] ram_waddr, ram_raddr;
  logic [KMAP_DW-1:0] ram_wdata, ram_rdata;

  // Output stage: one pending byte waits until the next result (last = 0) or the
  // end of the item (last = 1) decides its tlast, then moves to the output register.
  logic       pend_vld_q, pend_vld_d;
  logic       pend_kind_q, pend_kind_d;
  logic [7:0] pend_data_q, pend_data_d;
  logic       m_valid_q, m_valid_d;
  logic       m_kind_q, m_kind_d;
  logic [7:0] m_data_q, m_data_d;
  logic       m_last_q, m_last_d;
  logic       out_free;

  // Configuration: always ready, writes land at once.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_KEYMAP_ENABLE:  cfg_q.keymap_enable  <= cfg_data_i[0];
        CFG_KEYMAP_SIZE:    cfg_q.keymap_size    <= cfg_data_i;
        CFG_EXTENDED_ASCII: cfg_q.extended_ascii <= cfg_data_i[0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  hkrd_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .req_i       (s_axis_tuser_i),
    .data_i      (s_axis_tdata_i),
    .cfg_i       (cfg_q),
    .emit_rdy_i  (emit_rdy),
    .emit_o      (emit),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .enc_o       (enc_in),
    .enc_i       (enc_out)
  );

  hkrd_enc u_enc (
    .enc_i (enc_in),
    .enc_o (enc_out)
  );

  // Keymap table: lower case in bits 7..0, upper case in bits 15..8.
  hkrd_ram #(
    .WIDTH (KMAP_DW),
    .DEPTH (KEYMAP_DEPTH)
  ) u_keymap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free = !m_valid_q || m_axis_tready_i;
  assign emit_rdy = !pend_vld_q || out_free;

  always_comb begin
    pend_vld_d  = pend_vld_q;
    pend_kind_d = pend_kind_q;
    pend_data_d = pend_data_q;
    m_valid_d   = m_valid_q && !m_axis_tready_i;
    m_kind_d    = m_kind_q;
    m_data_d    = m_data_q;
    m_last_d    = m_last_q;
    if (emit.push && emit_rdy) begin
      // a newer result exists, so the pending one is not the last
      if (pend_vld_q) begin
        m_valid_d = 1'b1;
        m_kind_d  = pend_kind_q;
        m_data_d  = pend_data_q;
        m_last_d  = 1'b0;
      end
      pend_vld_d  = 1'b1;
      pend_kind_d = emit.kind;
      pend_data_d = emit.data;
    end else if (emit.flush && emit_rdy && pend_vld_q) begin
      m_valid_d  = 1'b1;
      m_kind_d   = pend_kind_q;
      m_data_d   = pend_data_q;
      m_last_d   = 1'b1;
      pend_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      pend_vld_q <= pend_vld_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_kind_q <= pend_kind_d;
    pend_data_q <= pend_data_d;
    m_kind_q    <= m_kind_d;
    m_data_q    <= m_data_d;
    m_last_q    <= m_last_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_kind_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

`default_nettype wire

>>> hdl/hkrd_checker.sv
`default_nettype none

module hkrd_checker import hkrd_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid_i,
  input wire logic       s_axis_tready_o,
  input wire logic [1:0] s_axis_tuser_i,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o,
  input wire logic       m_axis_tuser_o,
  input wire logic       m_axis_tlast_o
);

  // a report or an LED set keeps the block busy: ready drops right after it
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o &&
      ((s_axis_tuser_i == REQ_REPORT) || (s_axis_tuser_i == REQ_LED_SET)) |=>
      !s_axis_tready_o)
    else $error("input accepted while previous item in progress");

  // an LED update always closes its item and carries three LED bits only
  a_led_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == KIND_LED) |->
      m_axis_tlast_o && (m_axis_tdata_o[7:3] == 5'b0))
    else $error("LED update not final or malformed");

  // stalled output holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("output changed while stalled");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

endmodule

bind hid_keyboard_report_decoder hkrd_checker u_hkrd_checker (.*);

`default_nettype wire
